### rtl/clkts_pkg.sv
// Shared result type, constants and helper function of the time-of-day clock.
`default_nettype none
package clkts_pkg;

    localparam int CmdWidth   = 4;
    localparam int ValueWidth = 7;
    localparam int CfgWidth   = 8;

    // Command codes of the input word.
    localparam logic [CmdWidth-1:0] CMD_TICK    = 4'd0;
    localparam logic [CmdWidth-1:0] CMD_ACCEPT  = 4'd1;
    localparam logic [CmdWidth-1:0] CMD_CANCEL  = 4'd2;
    localparam logic [CmdWidth-1:0] CMD_RIGHT   = 4'd3;
    localparam logic [CmdWidth-1:0] CMD_UP      = 4'd4;
    localparam logic [CmdWidth-1:0] CMD_DOWN    = 4'd5;
    localparam logic [CmdWidth-1:0] CMD_LEFT    = 4'd6;
    localparam logic [CmdWidth-1:0] CMD_SET     = 4'd7;
    localparam logic [CmdWidth-1:0] CMD_EDIT    = 4'd8;
    localparam logic [CmdWidth-1:0] CMD_CONFIRM = 4'd9;
    localparam logic [CmdWidth-1:0] CMD_RESET   = 4'd10;

    // Configuration register indexes.
    localparam logic REG_TICK_PRESCALE = 1'b0;
    localparam logic REG_BLINK_PERIOD  = 1'b1;

    localparam logic [7:0] RESET_PRESCALE = 8'd150;
    localparam logic [6:0] RESET_BLINK    = 7'd80;

    // Cursor sections.
    localparam logic [1:0] SECT_SEC  = 2'd0;
    localparam logic [1:0] SECT_MIN  = 2'd1;
    localparam logic [1:0] SECT_HOUR = 2'd2;

    typedef struct packed {
        logic [3:0] sec_units;
        logic [2:0] sec_tens;
        logic [3:0] min_units;
        logic [2:0] min_tens;
        logic [3:0] hour_units;
        logic [1:0] hour_tens;
        logic       editing;
        logic [1:0] cursor_section;
        logic       blink_phase;
        logic       set_error;
    } result_t;

    // Splits a value below 64 into tens and units; tens by reciprocal 13/128.
    function automatic logic [7:0] to_bcd(input logic [5:0] v);
        logic [9:0] prod;
        logic [3:0] tens;
        logic [6:0] tens_x10;
        logic [3:0] units;
        prod     = {4'd0, v} * 10'd13;
        tens     = {1'b0, prod[9:7]};
        tens_x10 = {tens, 3'd0} - 7'd0 + {2'd0, tens, 1'b0};
        units    = 4'({1'b0, v} - tens_x10);
        return {tens, units};
    endfunction

endpackage
`default_nettype wire

### rtl/clkts_in_if.sv
// Input channel of the time-of-day clock: command word with set values.
`default_nettype none
interface clkts_in_if;
    logic                           valid;
    logic                           ready;
    logic [clkts_pkg::CmdWidth-1:0]   command;
    logic [clkts_pkg::ValueWidth-1:0] hour_value;
    logic [clkts_pkg::ValueWidth-1:0] minute_value;
    logic [clkts_pkg::ValueWidth-1:0] second_value;

    modport source (output valid, command, hour_value, minute_value, second_value,
                    input ready);
    modport sink (input valid, command, hour_value, minute_value, second_value,
                  output ready);
endinterface
`default_nettype wire

### rtl/clkts_out_if.sv
// Output channel of the time-of-day clock: display digits and status.
`default_nettype none
interface clkts_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] sec_units;
    logic [2:0] sec_tens;
    logic [3:0] min_units;
    logic [2:0] min_tens;
    logic [3:0] hour_units;
    logic [1:0] hour_tens;
    logic       editing;
    logic [1:0] cursor_section;
    logic       blink_phase;
    logic       set_error;

    modport source (output valid, sec_units, sec_tens, min_units, min_tens, hour_units,
                    hour_tens, editing, cursor_section, blink_phase, set_error,
                    input ready);
    modport sink (input valid, sec_units, sec_tens, min_units, min_tens, hour_units,
                  hour_tens, editing, cursor_section, blink_phase, set_error,
                  output ready);
endinterface
`default_nettype wire

### rtl/clock_with_time_setting.sv
// Time-of-day clock (hh:mm:ss) with edit mode, cursor and set command.
//
// Usage: every word on in_ch carries one command (tick, key or control) and,
// for the set command, an hour, minute and second value. Every accepted
// word yields exactly one word on out_ch with the six display digits, the
// edit flag, the cursor section, the blink phase and the set error flag, all
// as they stand after the command.
// The accepted word sits in the input register; once it advances, the state
// update and the result register load happen at the same edge, and the
// result register drives out_ch.valid. One word is accepted every cycle while
// the result register is not stalled; the rate is set by the single state
// update path between the input register and the result register.
// When out_ch.ready is low the result register holds its word, the input
// register still takes one more word, and in_ch.ready then drops until the
// result is taken. The reset rst_n clears the time, the digits and all flags,
// and loads the prescaler with 150 and the blink period with 80. Registers
// are written through cfg_we, cfg_index and cfg_data; the user must write them
// only while no word is in flight, as the block itself does not enforce this.
`default_nettype none
module clock_with_time_setting (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    clkts_in_if.sink                           in_ch,
    clkts_out_if.source                        out_ch,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_index,
    input  wire logic [clkts_pkg::CfgWidth-1:0] cfg_data
);

    // Configuration registers.
    logic [7:0] prescale_reg;
    logic [6:0] blink_period_reg;

    // Input register.
    logic                             s1_valid_reg;
    logic [clkts_pkg::CmdWidth-1:0]   s1_cmd_reg;
    logic [clkts_pkg::ValueWidth-1:0] s1_hour_reg;
    logic [clkts_pkg::ValueWidth-1:0] s1_min_reg;
    logic [clkts_pkg::ValueWidth-1:0] s1_sec_reg;
    logic                             s1_advance;

    // Clock state.
    logic [5:0] sec_reg, sec_next;
    logic [5:0] min_reg, min_next;
    logic [4:0] hour_reg, hour_next;
    logic [3:0] digit_reg [6];
    logic [3:0] digit_next [6];
    logic       edit_reg, edit_next;
    logic [1:0] sect_reg, sect_next;
    logic [7:0] tick_cnt_reg, tick_cnt_next;
    logic [6:0] blink_cnt_reg, blink_cnt_next;
    logic       blink_reg, blink_next;
    logic       pending_reg, pending_next;
    logic       err_reg, err_next;

    // Result register.
    logic                 out_valid_reg;
    clkts_pkg::result_t   out_reg;
    clkts_pkg::result_t   out_next;

    // Stepped digit pairs for each section, {tens, units}.
    logic [7:0] up_pair [3];
    logic [7:0] dn_pair [3];

    logic [7:0] sec_bcd, min_bcd, hour_bcd;
    logic [5:0] sec_from_dig, min_from_dig;
    logic [4:0] hour_from_dig;
    logic       set_bad;

    function automatic logic [7:0] step_up(input logic [3:0] d0_in, input logic [3:0] d1_in,
                                           input logic is_hour);
        logic [3:0] d0;
        logic [3:0] d1;
        d0 = d0_in + 4'd1;
        d1 = d1_in;
        if (d0 >= 4'd10)
        begin
            d0 = 4'd0;
            d1 = d1 + 4'd1;
        end
        if (!is_hour)
        begin
            if (d1 >= 4'd6)
            begin
                d1 = 4'd0;
            end
        end
        else if ((d0 == 4'd4 && d1 == 4'd2) || d1 > 4'd2)
        begin
            d0 = 4'd0;
            d1 = 4'd0;
        end
        return {d1, d0};
    endfunction

    function automatic logic [7:0] step_down(input logic [3:0] d0_in, input logic [3:0] d1_in,
                                             input logic is_hour);
        logic [3:0] d0;
        logic [3:0] d1;
        logic       under;
        d0    = d0_in;
        d1    = d1_in;
        under = 1'b0;
        if (d0 == 4'd0)
        begin
            d0 = 4'd9;
            if (d1 == 4'd0)
            begin
                under = 1'b1;
            end
            else
            begin
                d1 = d1 - 4'd1;
            end
        end
        else
        begin
            d0 = d0 - 4'd1;
        end
        if (under)
        begin
            if (!is_hour)
            begin
                d1 = 4'd5;
            end
            else
            begin
                d0 = 4'd3;
                d1 = 4'd2;
            end
        end
        return {d1, d0};
    endfunction

    function automatic logic [7:0] from_digits(input logic [3:0] d0, input logic [3:0] d1);
        return {4'd0, d0} + {1'b0, d1, 3'd0} + {3'd0, d1, 1'b0};
    endfunction

    // Handshake.
    assign s1_advance  = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            s1_cmd_reg  <= in_ch.command;
            s1_hour_reg <= in_ch.hour_value;
            s1_min_reg  <= in_ch.minute_value;
            s1_sec_reg  <= in_ch.second_value;
        end
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg     <= clkts_pkg::RESET_PRESCALE;
            blink_period_reg <= clkts_pkg::RESET_BLINK;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                clkts_pkg::REG_TICK_PRESCALE: prescale_reg     <= cfg_data;
                clkts_pkg::REG_BLINK_PERIOD:  blink_period_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Per-section digit steps, each reading its own fixed digit pair.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            up_pair[k] = step_up(digit_reg[2*k], digit_reg[2*k+1], k == 2);
            dn_pair[k] = step_down(digit_reg[2*k], digit_reg[2*k+1], k == 2);
        end
    end

    assign sec_bcd       = clkts_pkg::to_bcd(sec_reg);
    assign min_bcd       = clkts_pkg::to_bcd(min_reg);
    assign hour_bcd      = clkts_pkg::to_bcd({1'b0, hour_reg});
    assign sec_from_dig  = 6'(from_digits(digit_reg[0], digit_reg[1]));
    assign min_from_dig  = 6'(from_digits(digit_reg[2], digit_reg[3]));
    assign hour_from_dig = 5'(from_digits(digit_reg[4], digit_reg[5]));
    assign set_bad       = s1_hour_reg > 7'd23 || s1_min_reg > 7'd59 || s1_sec_reg > 7'd59;

    // State update for the word in the input register.
    always_comb
    begin
        logic [7:0] tc;
        logic [6:0] bc;
        logic       pend;
        logic [5:0] s_inc;
        logic [5:0] m_inc;
        logic [4:0] h_inc;

        sec_next       = sec_reg;
        min_next       = min_reg;
        hour_next      = hour_reg;
        for (int k = 0; k < 6; k++)
        begin
            digit_next[k] = digit_reg[k];
        end
        edit_next      = edit_reg;
        sect_next      = sect_reg;
        tick_cnt_next  = tick_cnt_reg;
        blink_cnt_next = blink_cnt_reg;
        blink_next     = blink_reg;
        pending_next   = pending_reg;
        err_next       = err_reg;
        tc             = tick_cnt_reg;
        bc             = blink_cnt_reg;
        pend           = pending_reg;
        s_inc          = sec_reg + 6'd1;
        m_inc          = min_reg;
        h_inc          = hour_reg;

        if (s1_advance)
        begin
            case (s1_cmd_reg)
                clkts_pkg::CMD_TICK:
                begin
                    if (tc >= prescale_reg)
                    begin
                        pend = 1'b1;
                        tc   = 8'd0;
                    end
                    if (!edit_reg)
                    begin
                        tc = tc + 8'd1;
                    end
                    else
                    begin
                        bc = bc + 7'd1;
                        if (bc == blink_period_reg)
                        begin
                            bc         = 7'd0;
                            blink_next = !blink_reg;
                        end
                    end
                    if (pend && !edit_reg)
                    begin
                        pend          = 1'b0;
                        digit_next[0] = sec_bcd[3:0];
                        digit_next[1] = sec_bcd[7:4];
                        digit_next[2] = min_bcd[3:0];
                        digit_next[3] = min_bcd[7:4];
                        digit_next[4] = hour_bcd[3:0];
                        digit_next[5] = hour_bcd[7:4];
                        // Seconds carry into minutes, minutes into hours.
                        if (s_inc >= 6'd60)
                        begin
                            s_inc = 6'd0;
                            m_inc = min_reg + 6'd1;
                        end
                        if (m_inc >= 6'd60)
                        begin
                            m_inc = 6'd0;
                            h_inc = hour_reg + 5'd1;
                        end
                        if (h_inc >= 5'd24)
                        begin
                            h_inc = 5'd0;
                        end
                        sec_next  = s_inc;
                        min_next  = m_inc;
                        hour_next = h_inc;
                    end
                    tick_cnt_next  = tc;
                    blink_cnt_next = bc;
                    pending_next   = pend;
                end
                clkts_pkg::CMD_ACCEPT:
                begin
                    if (edit_reg)
                    begin
                        sec_next      = sec_from_dig;
                        min_next      = min_from_dig;
                        hour_next     = hour_from_dig;
                        blink_next    = 1'b0;
                        edit_next     = 1'b0;
                        tick_cnt_next = prescale_reg;
                    end
                end
                clkts_pkg::CMD_CANCEL:
                begin
                    edit_next  = 1'b0;
                    blink_next = 1'b0;
                end
                clkts_pkg::CMD_RIGHT:
                begin
                    edit_next = 1'b1;
                    // Entering edit mode starts the move from minutes.
                    if (!edit_reg || sect_reg == clkts_pkg::SECT_MIN)
                    begin
                        sect_next = clkts_pkg::SECT_SEC;
                    end
                    else if (sect_reg == clkts_pkg::SECT_SEC)
                    begin
                        sect_next = clkts_pkg::SECT_HOUR;
                    end
                    else
                    begin
                        sect_next = sect_reg - 2'd1;
                    end
                    if (edit_reg && sect_reg > clkts_pkg::SECT_HOUR)
                    begin
                        sect_next = clkts_pkg::SECT_HOUR;
                    end
                    blink_cnt_next = 7'd0;
                end
                clkts_pkg::CMD_UP:
                begin
                    if (edit_reg)
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            if (sect_reg == 2'(k))
                            begin
                                digit_next[2*k]   = up_pair[k][3:0];
                                digit_next[2*k+1] = up_pair[k][7:4];
                            end
                        end
                    end
                end
                clkts_pkg::CMD_DOWN:
                begin
                    if (edit_reg)
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            if (sect_reg == 2'(k))
                            begin
                                digit_next[2*k]   = dn_pair[k][3:0];
                                digit_next[2*k+1] = dn_pair[k][7:4];
                            end
                        end
                    end
                end
                clkts_pkg::CMD_LEFT:
                begin
                    edit_next = 1'b1;
                    // Entering edit mode starts the move from hours.
                    if (!edit_reg || sect_reg >= clkts_pkg::SECT_HOUR)
                    begin
                        sect_next = clkts_pkg::SECT_SEC;
                    end
                    else
                    begin
                        sect_next = sect_reg + 2'd1;
                    end
                    blink_cnt_next = 7'd0;
                end
                clkts_pkg::CMD_SET:
                begin
                    if (set_bad)
                    begin
                        sec_next  = sec_from_dig;
                        min_next  = min_from_dig;
                        hour_next = hour_from_dig;
                        err_next  = 1'b1;
                    end
                    else
                    begin
                        sec_next  = s1_sec_reg[5:0];
                        min_next  = s1_min_reg[5:0];
                        hour_next = s1_hour_reg[4:0];
                        err_next  = 1'b0;
                    end
                    tick_cnt_next = prescale_reg;
                end
                clkts_pkg::CMD_EDIT:
                begin
                    err_next  = 1'b0;
                    edit_next = 1'b1;
                    sect_next = clkts_pkg::SECT_SEC;
                end
                clkts_pkg::CMD_CONFIRM:
                begin
                    err_next   = 1'b0;
                    sec_next   = sec_from_dig;
                    min_next   = min_from_dig;
                    hour_next  = hour_from_dig;
                    edit_next  = 1'b0;
                    blink_next = 1'b0;
                end
                clkts_pkg::CMD_RESET:
                begin
                    sec_next       = 6'd0;
                    min_next       = 6'd0;
                    hour_next      = 5'd0;
                    for (int k = 0; k < 6; k++)
                    begin
                        digit_next[k] = 4'd0;
                    end
                    edit_next      = 1'b0;
                    sect_next      = clkts_pkg::SECT_SEC;
                    tick_cnt_next  = prescale_reg;
                    blink_cnt_next = 7'd0;
                    blink_next     = 1'b0;
                    pending_next   = 1'b0;
                    err_next       = 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_reg       <= 6'd0;
            min_reg       <= 6'd0;
            hour_reg      <= 5'd0;
            for (int k = 0; k < 6; k++)
            begin
                digit_reg[k] <= 4'd0;
            end
            edit_reg      <= 1'b0;
            sect_reg      <= clkts_pkg::SECT_SEC;
            tick_cnt_reg  <= clkts_pkg::RESET_PRESCALE;
            blink_cnt_reg <= 7'd0;
            blink_reg     <= 1'b0;
            pending_reg   <= 1'b0;
            err_reg       <= 1'b0;
        end
        else
        begin
            sec_reg       <= sec_next;
            min_reg       <= min_next;
            hour_reg      <= hour_next;
            for (int k = 0; k < 6; k++)
            begin
                digit_reg[k] <= digit_next[k];
            end
            edit_reg      <= edit_next;
            sect_reg      <= sect_next;
            tick_cnt_reg  <= tick_cnt_next;
            blink_cnt_reg <= blink_cnt_next;
            blink_reg     <= blink_next;
            pending_reg   <= pending_next;
            err_reg       <= err_next;
        end
    end

    // Result word: the state as it stands after the command.
    always_comb
    begin
        out_next.sec_units      = digit_next[0];
        out_next.sec_tens       = digit_next[1][2:0];
        out_next.min_units      = digit_next[2];
        out_next.min_tens       = digit_next[3][2:0];
        out_next.hour_units     = digit_next[4];
        out_next.hour_tens      = digit_next[5][1:0];
        out_next.editing        = edit_next;
        out_next.cursor_section = sect_next;
        out_next.blink_phase    = blink_next;
        out_next.set_error      = err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_reg <= out_next;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.sec_units      = out_reg.sec_units;
    assign out_ch.sec_tens       = out_reg.sec_tens;
    assign out_ch.min_units      = out_reg.min_units;
    assign out_ch.min_tens       = out_reg.min_tens;
    assign out_ch.hour_units     = out_reg.hour_units;
    assign out_ch.hour_tens      = out_reg.hour_tens;
    assign out_ch.editing        = out_reg.editing;
    assign out_ch.cursor_section = out_reg.cursor_section;
    assign out_ch.blink_phase    = out_reg.blink_phase;
    assign out_ch.set_error      = out_reg.set_error;

    // The cursor never reaches the unused fourth code.
    a_sect_range: assert property (@(posedge clk) disable iff (!rst_n)
        sect_reg != 2'd3)
        else $error("cursor section out of range");

    // The blink phase is only ever on while editing.
    a_blink_edit: assert property (@(posedge clk) disable iff (!rst_n)
        blink_reg |-> edit_reg)
        else $error("blink phase set outside edit mode");

    // The running time stays a legal time of day.
    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        sec_reg < 6'd60 && min_reg < 6'd60 && hour_reg < 5'd24)
        else $error("time counters out of range");

    // A word held back by a stalled result register is not dropped.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_advance |=> s1_valid_reg && $stable(s1_cmd_reg))
        else $error("input word lost while stalled");

endmodule
`default_nettype wire

### tb/clock_with_time_setting_test.sv
// Self-checking testbench of the time-of-day clock: directed table, then random phases.
`timescale 1ns / 100ps
module clock_with_time_setting_test;
    import clkts_pkg::*;

    localparam int CycleLimit = 200_000;
    // Command codes above reset have no effect but still return a word.
    localparam logic [CmdWidth-1:0] CMD_SPARE_TOP = CMD_RESET + 4'd5;

    typedef struct packed {
        logic [CmdWidth-1:0]   cmd;
        logic [ValueWidth-1:0] hv;
        logic [ValueWidth-1:0] mv;
        logic [ValueWidth-1:0] sv;
    } word_t;

    typedef struct {
        word_t   w;
        bit      typed;
        result_t want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic [CfgWidth-1:0] cfg_data;

    clkts_in_if  in_ch ();
    clkts_out_if out_ch ();

    clock_with_time_setting i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Mirror of the clock state and its registers.
    logic [5:0] now_sec;
    logic [5:0] now_min;
    logic [4:0] now_hour;
    logic [3:0] digit [6];
    logic       edit_on;
    logic [1:0] cursor;
    logic [7:0] tick_cnt;
    logic [6:0] blink_cnt;
    logic       blink_on;
    logic       advance_due;
    logic       set_err_flag;
    logic [7:0] prescale_reg;
    logic [6:0] blink_reg;

    result_t display_q [$];
    row_t    script [$];

    int words_sent    = 0;
    int results_taken = 0;
    int mismatches    = 0;
    int settings_run  = 0;
    int clock_steps   = 0;
    int edit_words    = 0;
    int sets_rejected = 0;
    int cycles        = 0;

    function automatic void restart_clock();
        now_sec      = '0;
        now_min      = '0;
        now_hour     = '0;
        foreach (digit[i])
            digit[i] = '0;
        edit_on      = 1'b0;
        cursor       = SECT_SEC;
        tick_cnt     = prescale_reg;
        blink_cnt    = '0;
        blink_on     = 1'b0;
        advance_due  = 1'b0;
        set_err_flag = 1'b0;
    endfunction

    function automatic void load_time_from_digits();
        now_sec  = 6'(int'(digit[0]) + 10 * int'(digit[1]));
        now_min  = 6'(int'(digit[2]) + 10 * int'(digit[3]));
        now_hour = 5'(int'(digit[4]) + 10 * int'(digit[5]));
    endfunction

    // Applies one word to the mirrored state and returns the display it leaves.
    function automatic result_t next_display(word_t w);
        result_t r;
        int b;
        b = 2 * int'(cursor);
        case (w.cmd)
            CMD_TICK:
            begin
                if (tick_cnt >= prescale_reg)
                begin
                    advance_due = 1'b1;
                    tick_cnt    = '0;
                end
                if (!edit_on)
                    tick_cnt = tick_cnt + 8'd1;
                else
                begin
                    blink_cnt = blink_cnt + 7'd1;
                    if (blink_cnt == blink_reg)
                    begin
                        blink_cnt = '0;
                        blink_on  = ~blink_on;
                    end
                end
                // The display shows the time as it stood before the advance.
                if (advance_due && !edit_on)
                begin
                    advance_due = 1'b0;
                    digit[0] = 4'(now_sec % 10);
                    digit[1] = 4'(now_sec / 10);
                    digit[2] = 4'(now_min % 10);
                    digit[3] = 4'(now_min / 10);
                    digit[4] = 4'(now_hour % 10);
                    digit[5] = 4'(now_hour / 10);
                    now_sec  = now_sec + 6'd1;
                    if (now_sec >= 60)
                    begin
                        now_sec = '0;
                        now_min = now_min + 6'd1;
                    end
                    if (now_min >= 60)
                    begin
                        now_min  = '0;
                        now_hour = now_hour + 5'd1;
                    end
                    if (now_hour >= 24)
                        now_hour = '0;
                    clock_steps++;
                end
            end
            CMD_ACCEPT:
            begin
                if (edit_on)
                begin
                    load_time_from_digits();
                    blink_on = 1'b0;
                    edit_on  = 1'b0;
                    tick_cnt = prescale_reg;
                end
            end
            CMD_CANCEL:
            begin
                edit_on  = 1'b0;
                blink_on = 1'b0;
            end
            CMD_RIGHT:
            begin
                if (!edit_on)
                begin
                    edit_on = 1'b1;
                    cursor  = SECT_MIN;
                end
                cursor    = (cursor == SECT_SEC) ? SECT_HOUR : cursor - 2'd1;
                blink_cnt = '0;
            end
            CMD_UP:
            begin
                if (edit_on)
                begin
                    digit[b] = digit[b] + 4'd1;
                    if (digit[b] >= 10)
                    begin
                        digit[b]     = '0;
                        digit[b + 1] = digit[b + 1] + 4'd1;
                    end
                    if (cursor != SECT_HOUR)
                    begin
                        if (digit[b + 1] >= 6)
                            digit[b + 1] = '0;
                    end
                    else if ((digit[b] == 4 && digit[b + 1] == 2) || digit[b + 1] > 2)
                    begin
                        digit[b]     = '0;
                        digit[b + 1] = '0;
                    end
                end
            end
            CMD_DOWN:
            begin
                if (edit_on)
                begin
                    if (digit[b] == 0)
                    begin
                        digit[b] = 4'd9;
                        if (digit[b + 1] != 0)
                            digit[b + 1] = digit[b + 1] - 4'd1;
                        else if (cursor != SECT_HOUR)
                            digit[b + 1] = 4'd5;
                        else
                        begin
                            digit[b]     = 4'd3;
                            digit[b + 1] = 4'd2;
                        end
                    end
                    else
                        digit[b] = digit[b] - 4'd1;
                end
            end
            CMD_LEFT:
            begin
                if (!edit_on)
                begin
                    edit_on = 1'b1;
                    cursor  = SECT_HOUR;
                end
                cursor    = (cursor >= SECT_HOUR) ? SECT_SEC : cursor + 2'd1;
                blink_cnt = '0;
            end
            CMD_SET:
            begin
                set_err_flag = 1'b0;
                if (w.hv > 23 || w.mv > 59 || w.sv > 59)
                begin
                    load_time_from_digits();
                    set_err_flag = 1'b1;
                    sets_rejected++;
                end
                else
                begin
                    now_hour = w.hv[4:0];
                    now_min  = w.mv[5:0];
                    now_sec  = w.sv[5:0];
                end
                tick_cnt = prescale_reg;
            end
            CMD_EDIT:
            begin
                set_err_flag = 1'b0;
                edit_on      = 1'b1;
                cursor       = SECT_SEC;
            end
            CMD_CONFIRM:
            begin
                set_err_flag = 1'b0;
                load_time_from_digits();
                edit_on  = 1'b0;
                blink_on = 1'b0;
            end
            CMD_RESET:
                restart_clock();
            default:
                ;
        endcase
        if (edit_on)
            edit_words++;
        r.sec_units      = digit[0];
        r.sec_tens       = digit[1][2:0];
        r.min_units      = digit[2];
        r.min_tens       = digit[3][2:0];
        r.hour_units     = digit[4];
        r.hour_tens      = digit[5][1:0];
        r.editing        = edit_on;
        r.cursor_section = cursor;
        r.blink_phase    = blink_on;
        r.set_error      = set_err_flag;
        return r;
    endfunction

    // Display outside edit mode, for rows whose result is plain to see.
    function automatic result_t shown(int hh, int mm, int ss, bit err);
        result_t r;
        r            = '0;
        r.sec_units  = 4'(ss % 10);
        r.sec_tens   = 3'(ss / 10);
        r.min_units  = 4'(mm % 10);
        r.min_tens   = 3'(mm / 10);
        r.hour_units = 4'(hh % 10);
        r.hour_tens  = 2'(hh / 10);
        r.set_error  = err;
        return r;
    endfunction

    function automatic void add_row(logic [CmdWidth-1:0] cmd, int h = 0, int m = 0, int s = 0,
                                    bit typed = 1'b0, result_t want = '0);
        row_t row;
        row.w     = '{cmd: cmd, hv: 7'(h), mv: 7'(m), sv: 7'(s)};
        row.typed = typed;
        row.want  = want;
        script.push_back(row);
    endfunction

    function automatic string show(result_t r);
        return $sformatf("%0d%0d:%0d%0d:%0d%0d edit=%0d cursor=%0d blink=%0d err=%0d",
                         r.hour_tens, r.hour_units, r.min_tens, r.min_units, r.sec_tens,
                         r.sec_units, r.editing, r.cursor_section, r.blink_phase, r.set_error);
    endfunction

    function automatic string diff_fields(result_t e, result_t a);
        string s;
        s = "";
        if (a.sec_units !== e.sec_units)           s = {s, " sec_units"};
        if (a.sec_tens !== e.sec_tens)             s = {s, " sec_tens"};
        if (a.min_units !== e.min_units)           s = {s, " min_units"};
        if (a.min_tens !== e.min_tens)             s = {s, " min_tens"};
        if (a.hour_units !== e.hour_units)         s = {s, " hour_units"};
        if (a.hour_tens !== e.hour_tens)           s = {s, " hour_tens"};
        if (a.editing !== e.editing)               s = {s, " editing"};
        if (a.cursor_section !== e.cursor_section) s = {s, " cursor_section"};
        if (a.blink_phase !== e.blink_phase)       s = {s, " blink_phase"};
        if (a.set_error !== e.set_error)           s = {s, " set_error"};
        return s;
    endfunction

    // Mostly ticks and edit keys; sets lean toward the wrap points of the day.
    function automatic word_t pick_word();
        word_t w;
        int k;
        k    = $urandom_range(0, 99);
        w.hv = 7'($urandom);
        w.mv = 7'($urandom);
        w.sv = 7'($urandom);
        if (k < 35)      w.cmd = CMD_TICK;
        else if (k < 47) w.cmd = CMD_UP;
        else if (k < 57) w.cmd = CMD_DOWN;
        else if (k < 62) w.cmd = CMD_RIGHT;
        else if (k < 67) w.cmd = CMD_LEFT;
        else if (k < 71) w.cmd = CMD_EDIT;
        else if (k < 75) w.cmd = CMD_ACCEPT;
        else if (k < 78) w.cmd = CMD_CONFIRM;
        else if (k < 81) w.cmd = CMD_CANCEL;
        else if (k < 95) w.cmd = CMD_SET;
        else if (k < 97) w.cmd = CMD_RESET;
        else             w.cmd = CMD_RESET + 4'($urandom_range(1, 5));
        if (w.cmd == CMD_SET)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                w.hv = 7'd23;
                w.mv = 7'd59;
                w.sv = 7'($urandom_range(50, 59));
            end
            else
            begin
                w.hv = 7'($urandom_range(0, 23));
                w.mv = 7'($urandom_range(0, 59));
                w.sv = 7'($urandom_range(0, 59));
            end
            case ($urandom_range(0, 5))
                0:       w.hv = 7'($urandom_range(24, 127));
                1:       w.mv = 7'($urandom_range(60, 127));
                2:       w.sv = 7'($urandom_range(60, 127));
                default: ;
            endcase
        end
        return w;
    endfunction

    // Called at a rising edge; returns at the edge where the word is taken.
    task automatic send_word(input word_t w, input bit typed, input result_t want);
        int gap;
        result_t r;
        gap = ((words_sent / 40) % 4 == 1) ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.command      <= w.cmd;
        in_ch.hour_value   <= w.hv;
        in_ch.minute_value <= w.mv;
        in_ch.second_value <= w.sv;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        r = next_display(w);
        display_q.push_back(typed ? want : r);
        words_sent++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (display_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CfgWidth-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx == REG_TICK_PRESCALE)
            prescale_reg = val;
        else
            blink_reg = val[6:0];
    endtask

    task automatic run_phase(input logic [7:0] pre, input logic [6:0] blink, input int n);
        drain();
        write_reg(REG_TICK_PRESCALE, pre);
        write_reg(REG_BLINK_PERIOD, {1'b0, blink});
        cfg_we <= 1'b0;
        settings_run++;
        repeat (n) send_word(pick_word(), 1'b0, '0);
    endtask

    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = REG_TICK_PRESCALE;
        cfg_data           = '0;
        in_ch.valid        = 1'b0;
        in_ch.command      = CMD_TICK;
        in_ch.hour_value   = '0;
        in_ch.minute_value = '0;
        in_ch.second_value = '0;
        prescale_reg       = RESET_PRESCALE;
        blink_reg          = RESET_BLINK;
        restart_clock();

        // The counter starts at the prescale value, so the first tick updates at once.
        add_row(CMD_TICK, 0, 0, 0, 1'b1, shown(0, 0, 0, 1'b0));
        add_row(CMD_SET, 127, 127, 127, 1'b1, shown(0, 0, 0, 1'b1));
        add_row(CMD_SET, 24, 0, 0, 1'b1, shown(0, 0, 0, 1'b1));
        add_row(CMD_SET, 0, 60, 0, 1'b1, shown(0, 0, 0, 1'b1));
        add_row(CMD_SET, 0, 0, 60, 1'b1, shown(0, 0, 0, 1'b1));
        add_row(CMD_SET, 23, 59, 59, 1'b1, shown(0, 0, 0, 1'b0));
        add_row(CMD_TICK, 0, 0, 0, 1'b1, shown(23, 59, 59, 1'b0));
        add_row(CMD_EDIT);
        add_row(CMD_UP);
        add_row(CMD_DOWN);
        add_row(CMD_LEFT);
        add_row(CMD_LEFT);
        add_row(CMD_UP);
        add_row(CMD_DOWN);
        add_row(CMD_LEFT);
        add_row(CMD_RIGHT);
        add_row(CMD_TICK);
        add_row(CMD_CANCEL);
        add_row(CMD_UP);
        add_row(CMD_RIGHT);
        add_row(CMD_CONFIRM);
        add_row(CMD_LEFT);
        add_row(CMD_ACCEPT);
        add_row(CMD_SPARE_TOP, 127, 127, 127);
        add_row(CMD_RESET, 0, 0, 0, 1'b1, shown(0, 0, 0, 1'b0));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (script[i])
            send_word(script[i].w, script[i].typed, script[i].want);

        run_phase(8'd1, 7'd1, 85);
        // A zero prescale advances on every tick; a zero blink period toggles on wrap.
        run_phase(8'd0, 7'd0, 85);
        run_phase(8'd255, 7'd127, 85);
        run_phase(8'd2, 7'd3, 85);
        run_phase(8'd1, 7'd5, 85);
        run_phase(8'd4, 7'd2, 85);
        drain();
        repeat (4) @(posedge clk);

        $display("covered %0d words under %0d register settings beyond reset, %0d results",
                 words_sent, settings_run, results_taken);
        $display("clock advanced %0d times, %0d words in edit mode, %0d sets rejected",
                 clock_steps, edit_words, sets_rejected);
        if (mismatches == 0 && display_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Receiver: random stalls, quiet stretches and one long hold-off.
    initial
    begin : taker
        int stall;
        int seen;
        bit held;
        out_ch.ready = 1'b0;
        seen = 0;
        held = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!held && seen >= 300)
            begin
                stall = 60;
                held  = 1'b1;
            end
            else if ((seen / 50) % 4 == 2)
                stall = 0;
            else
                stall = $urandom_range(0, 11);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (out_ch.valid !== 1'b1);
            seen++;
        end
    end

    always @(posedge clk)
    begin : check_word
        result_t want;
        result_t got;
        string diff;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            results_taken++;
            got.sec_units      = out_ch.sec_units;
            got.sec_tens       = out_ch.sec_tens;
            got.min_units      = out_ch.min_units;
            got.min_tens       = out_ch.min_tens;
            got.hour_units     = out_ch.hour_units;
            got.hour_tens      = out_ch.hour_tens;
            got.editing        = out_ch.editing;
            got.cursor_section = out_ch.cursor_section;
            got.blink_phase    = out_ch.blink_phase;
            got.set_error      = out_ch.set_error;
            if (display_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word at %0t: %s", $realtime, show(got));
            end
            else
            begin
                want = display_q.pop_front();
                diff = diff_fields(want, got);
                if (diff != "")
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at %0t on%s: expected %s, got %s",
                                 $realtime, diff, show(want), show(got));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycles, display_q.size());
            $display("status: fail");
            $finish;
        end
    end

endmodule

### files.f
rtl/clkts_pkg.sv
rtl/clkts_in_if.sv
rtl/clkts_out_if.sv
rtl/clock_with_time_setting.sv
tb/clock_with_time_setting_test.sv
